>>> hdl/alkd_pkg.sv
// Shared types, constants and register codes for the ladder key decoder.
`default_nettype none
package alkd_pkg;

  // Sample width in use and song list limit
  localparam int AdcBits  = 12;
  localparam int MaxSongs = 16;

  localparam logic [11:0] SampleMask = 12'((64'd1 << AdcBits) - 64'd1);
  localparam logic [4:0]  SongLimit  = (MaxSongs < 16) ? 5'(MaxSongs) : 5'd16;

  // Reset values
  localparam logic [11:0] LowThrReset   = 12'd400;
  localparam logic [11:0] MidThrReset   = 12'd2800;
  localparam logic [7:0]  HoldReset     = 8'd25;
  localparam logic [6:0]  StepReset     = 7'd10;
  localparam logic [6:0]  FloorReset    = 7'd10;
  localparam logic [6:0]  CeilReset     = 7'd100;
  localparam logic [4:0]  SongTotReset  = 5'd3;
  localparam logic [3:0]  ConfirmReset  = 4'd2;
  localparam logic [6:0]  VolumeReset   = 7'd70;

  localparam logic [7:0]  HeldMax       = 8'hFF;
  localparam logic [3:0]  BootCountMax  = 4'hF;

  // Register map, word index
  typedef enum logic [2:0] {
    RegLowThr   = 3'd0,
    RegMidThr   = 3'd1,
    RegHold     = 3'd2,
    RegStep     = 3'd3,
    RegFloor    = 3'd4,
    RegCeil     = 3'd5,
    RegSongTot  = 3'd6,
    RegConfirm  = 3'd7
  } alkd_reg_e;

  // Latched ladder key codes
  typedef enum logic [1:0] {
    KeyNone = 2'd0,
    KeyLow  = 2'd1,
    KeyMid  = 2'd2
  } alkd_key_e;

  typedef struct packed {
    logic [11:0] low_thr;
    logic [11:0] mid_thr;
    logic [7:0]  hold_ticks;
    logic [6:0]  vol_step;
    logic [6:0]  vol_floor;
    logic [6:0]  vol_ceil;
    logic [4:0]  song_total;
    logic [3:0]  confirm;
  } alkd_cfg_t;

  typedef struct packed {
    logic [1:0] key_down;
    logic       song_changed;
    logic [3:0] song_index;
    logic       volume_changed;
    logic [6:0] volume_level;
    logic       playing;
  } alkd_res_t;

endpackage
`default_nettype wire

>>> hdl/alkd_cfg_regs.sv
// APB configuration register file for the ladder key decoder.
`default_nettype none
module alkd_cfg_regs
  import alkd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output alkd_cfg_t        cfg_o
);

  alkd_cfg_t cfg_q;
  alkd_reg_e sel;
  logic      wr_en;

  assign pready = 1'b1;
  assign sel    = alkd_reg_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr    <= LowThrReset;
      cfg_q.mid_thr    <= MidThrReset;
      cfg_q.hold_ticks <= HoldReset;
      cfg_q.vol_step   <= StepReset;
      cfg_q.vol_floor  <= FloorReset;
      cfg_q.vol_ceil   <= CeilReset;
      cfg_q.song_total <= SongTotReset;
      cfg_q.confirm    <= ConfirmReset;
    end else if (wr_en) begin
      case (sel)
        RegLowThr:  cfg_q.low_thr    <= pwdata[11:0];
        RegMidThr:  cfg_q.mid_thr    <= pwdata[11:0];
        RegHold:    cfg_q.hold_ticks <= pwdata[7:0];
        RegStep:    cfg_q.vol_step   <= pwdata[6:0];
        RegFloor:   cfg_q.vol_floor  <= pwdata[6:0];
        RegCeil:    cfg_q.vol_ceil   <= pwdata[6:0];
        RegSongTot: cfg_q.song_total <= pwdata[4:0];
        RegConfirm: cfg_q.confirm    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (sel)
      RegLowThr:  prdata = {20'd0, cfg_q.low_thr};
      RegMidThr:  prdata = {20'd0, cfg_q.mid_thr};
      RegHold:    prdata = {24'd0, cfg_q.hold_ticks};
      RegStep:    prdata = {25'd0, cfg_q.vol_step};
      RegFloor:   prdata = {25'd0, cfg_q.vol_floor};
      RegCeil:    prdata = {25'd0, cfg_q.vol_ceil};
      RegSongTot: prdata = {27'd0, cfg_q.song_total};
      RegConfirm: prdata = {28'd0, cfg_q.confirm};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/alkd_core.sv
// Decoder state and its one-tick update: ladder keys, volume, play and song.
`default_nettype none
module alkd_core
  import alkd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [11:0] sample_i,
  input  wire logic        boot_level_i,
  input  alkd_cfg_t        cfg_i,
  output alkd_res_t        res_o
);

  alkd_key_e  key_q, key_d, key_seen;
  logic [7:0] held_q, held_d, held_inc;
  logic       play_q, play_d;
  logic [6:0] vol_q, vol_d;
  logic [3:0] song_q, song_d;
  logic [3:0] boot_cnt_q, boot_cnt_d, boot_cnt_inc, need;
  logic       boot_acc_q, boot_acc_d;
  logic       vol_chg, song_chg;
  logic [11:0] sample;
  logic [4:0] total, song_nxt;
  logic [7:0] vol_dec, vol_inc;

  assign sample = sample_i & SampleMask;

  // Classify the sample; low key wins when thresholds cross
  always_comb begin
    if (sample < cfg_i.low_thr) begin
      key_seen = KeyLow;
    end else if (sample < cfg_i.mid_thr) begin
      key_seen = KeyMid;
    end else begin
      key_seen = KeyNone;
    end
  end

  // Effective song total, never zero
  always_comb begin
    total = (cfg_i.song_total > SongLimit) ? SongLimit : cfg_i.song_total;
    if (total == 5'd0) begin
      total = 5'd1;
    end
    song_nxt = {1'b0, song_q} + 5'd1;
    if (song_nxt >= total) begin
      song_nxt = 5'd0;
    end
  end

  assign held_inc     = (held_q == HeldMax) ? HeldMax : held_q + 8'd1;
  assign boot_cnt_inc = (boot_cnt_q == BootCountMax) ? BootCountMax : boot_cnt_q + 4'd1;
  assign need         = (cfg_i.confirm == 4'd0) ? 4'd1 : cfg_i.confirm;
  assign vol_dec      = {1'b0, vol_q} - {1'b0, cfg_i.vol_step};
  assign vol_inc      = {1'b0, vol_q} + {1'b0, cfg_i.vol_step};

  // Next state for one tick
  always_comb begin
    key_d      = key_q;
    held_d     = held_q;
    play_d     = play_q;
    vol_d      = vol_q;
    song_d     = song_q;
    boot_cnt_d = boot_cnt_q;
    boot_acc_d = boot_acc_q;
    vol_chg    = 1'b0;
    song_chg   = 1'b0;
    if (!boot_level_i) begin
      // Boot held: freeze the ladder, confirm the press once
      boot_cnt_d = boot_cnt_inc;
      if (!boot_acc_q && (boot_cnt_inc >= need)) begin
        song_d     = song_nxt[3:0];
        boot_acc_d = 1'b1;
        song_chg   = 1'b1;
      end
    end else begin
      boot_cnt_d = 4'd0;
      boot_acc_d = 1'b0;
      if (key_q == KeyNone) begin
        if (key_seen != KeyNone) begin
          key_d  = key_seen;
          held_d = 8'd0;
        end
      end else begin
        held_d = held_inc;
        if (key_seen == KeyNone) begin
          // Release: act on the latched key
          if (key_q == KeyMid) begin
            play_d = ~play_q;
          end else begin
            if (held_inc > cfg_i.hold_ticks) begin
              if (vol_dec[7] || (vol_dec[6:0] < cfg_i.vol_floor)) begin
                vol_d = cfg_i.vol_floor;
              end else begin
                vol_d = vol_dec[6:0];
              end
            end else begin
              if (vol_inc > {1'b0, cfg_i.vol_ceil}) begin
                vol_d = cfg_i.vol_ceil;
              end else begin
                vol_d = vol_inc[6:0];
              end
            end
            vol_chg = 1'b1;
          end
          key_d = KeyNone;
        end
      end
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= KeyNone;
      held_q     <= 8'd0;
      play_q     <= 1'b1;
      vol_q      <= VolumeReset;
      song_q     <= 4'd0;
      boot_cnt_q <= 4'd0;
      boot_acc_q <= 1'b0;
    end else if (step_i) begin
      key_q      <= key_d;
      held_q     <= held_d;
      play_q     <= play_d;
      vol_q      <= vol_d;
      song_q     <= song_d;
      boot_cnt_q <= boot_cnt_d;
      boot_acc_q <= boot_acc_d;
    end
  end

  // Result of this tick, from the updated state
  always_comb begin
    res_o.playing        = play_d;
    res_o.volume_level   = vol_d;
    res_o.volume_changed = vol_chg;
    res_o.song_index     = song_d;
    res_o.song_changed   = song_chg;
    res_o.key_down       = key_d;
  end

endmodule
`default_nettype wire

>>> hdl/adc_ladder_key_decoder_unit.sv
// A tick waits in the input register until the result register is free; its result is
// then written to the result register and offered on the master side from there.
// Throughput: one tick per cycle while the master takes results; the state update
// between the input and result registers is a single pass of compares and adds.
// The result register lets a new tick enter while a result waits to be taken.
// Reset (rst_ni low, asynchronous): registers return to their defaults, the
// key, volume, play and song state to its reset values, both stages empty.
`default_nettype none
module adc_ladder_key_decoder_unit
  import alkd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: [11:0] adc_sample, [12] boot_level, [15:13] zero
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  // tdata: [0] playing, [7:1] volume_level, [8] volume_changed,
  //        [12:9] song_index, [13] song_changed, [15:14] key_down
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  alkd_cfg_t   cfg;
  alkd_res_t   res;
  logic        in_vld_q;
  logic [11:0] sample_q;
  logic        boot_q;
  logic        out_vld_q;
  alkd_res_t   out_q;
  logic        advance;

  alkd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a tick into the result register when that slot is free
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sample_q <= s_axis_tdata[11:0];
      boot_q   <= s_axis_tdata[12];
    end
  end

  alkd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .sample_i     (sample_q),
    .boot_level_i (boot_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

>>> tb/adc_ladder_key_decoder_unit_tb.sv
// Self-checking testbench for the ladder key decoder: stream traffic, APB setup, live prediction.
`timescale 1ns / 1ps
module adc_ladder_key_decoder_unit_tb;
  import alkd_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int HoldOffLen  = 80;
  localparam int PrintLimit  = 30;

  typedef struct packed {
    logic [11:0] sample;
    logic        boot;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  adc_ladder_key_decoder_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pending ticks, expected player status, mismatch tally
  tick_t     tick_q[$];
  alkd_res_t status_q[$];
  int        mismatch_count = 0;
  bit        holdoff_req = 1'b0;

  // Shadow of the settings and of the player state
  alkd_cfg_t player_cfg;
  alkd_key_e latched;
  logic [7:0] held;
  logic       playing;
  logic [6:0] volume;
  logic [3:0] song;
  logic [3:0] boot_run;
  logic       boot_taken;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PrintLimit)
      $display("%0t: mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic reset_player();
    player_cfg = '{low_thr: LowThrReset, mid_thr: MidThrReset, hold_ticks: HoldReset,
                   vol_step: StepReset, vol_floor: FloorReset, vol_ceil: CeilReset,
                   song_total: SongTotReset, confirm: ConfirmReset};
    latched    = KeyNone;
    held       = '0;
    playing    = 1'b1;
    volume     = VolumeReset;
    song       = '0;
    boot_run   = '0;
    boot_taken = 1'b0;
  endtask

  // Advance the player by one poll tick and return the status it shows
  function automatic alkd_res_t advance_player(input tick_t t);
    alkd_res_t  r;
    alkd_key_e  seen;
    logic [11:0] smp;
    logic [3:0] need;
    logic [4:0] total;
    int         vol;
    smp = t.sample & SampleMask;
    r.volume_changed = 1'b0;
    r.song_changed   = 1'b0;
    if (!t.boot) begin
      // Boot held: ladder frozen, count low ticks toward confirmation
      need = (player_cfg.confirm == 4'd0) ? 4'd1 : player_cfg.confirm;
      if (boot_run != BootCountMax) boot_run++;
      if (!boot_taken && boot_run >= need) begin
        total = player_cfg.song_total;
        if (total > SongLimit) total = SongLimit;
        if (total == 5'd0) total = 5'd1;
        if ({1'b0, song} + 5'd1 >= total) song = '0;
        else song = song + 4'd1;
        boot_taken = 1'b1;
        r.song_changed = 1'b1;
      end
    end else begin
      boot_run   = '0;
      boot_taken = 1'b0;
      if (smp < player_cfg.low_thr) seen = KeyLow;
      else if (smp < player_cfg.mid_thr) seen = KeyMid;
      else seen = KeyNone;
      if (latched == KeyNone) begin
        if (seen != KeyNone) begin
          latched = seen;
          held    = '0;
        end
      end else begin
        if (held != HeldMax) held++;
        // Release: act on the latched key
        if (seen == KeyNone) begin
          if (latched == KeyMid) begin
            playing = ~playing;
          end else begin
            vol = int'(volume);
            if (held > player_cfg.hold_ticks) begin
              vol -= int'(player_cfg.vol_step);
              if (vol < int'(player_cfg.vol_floor)) vol = int'(player_cfg.vol_floor);
            end else begin
              vol += int'(player_cfg.vol_step);
              if (vol > int'(player_cfg.vol_ceil)) vol = int'(player_cfg.vol_ceil);
            end
            volume = 7'(vol);
            r.volume_changed = 1'b1;
          end
          latched = KeyNone;
        end
      end
    end
    r.playing      = playing;
    r.volume_level = volume;
    r.song_index   = song;
    r.key_down     = latched;
    return r;
  endfunction

  // Sender: offer queued ticks with random gaps
  tick_t cur_tick;
  int    in_gap = 0;
  bit    in_burst = 1'b0;
  logic  in_next_valid;

  always @(posedge clk) begin
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      in_next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(advance_player(cur_tick));
        in_next_valid = 1'b0;
        if ($urandom_range(0, 23) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          in_next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= in_next_valid;
      s_axis_tdata  <= {3'b000, cur_tick.boot, cur_tick.sample};
    end
  end

  // Receiver: check each result transfer, stall at random, hold off on request
  alkd_res_t got, want;
  int        out_stall = 0;
  int        holdoff_left = 0;
  bit        out_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alkd_res_t'(m_axis_tdata);
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
        end else begin
          want = status_q.pop_front();
          if (got.playing != want.playing)
            report_mismatch("playing", got.playing, want.playing);
          if (got.volume_level != want.volume_level)
            report_mismatch("volume_level", got.volume_level, want.volume_level);
          if (got.volume_changed != want.volume_changed)
            report_mismatch("volume_changed", got.volume_changed, want.volume_changed);
          if (got.song_index != want.song_index)
            report_mismatch("song_index", got.song_index, want.song_index);
          if (got.song_changed != want.song_changed)
            report_mismatch("song_changed", got.song_changed, want.song_changed);
          if (got.key_down != want.key_down)
            report_mismatch("key_down", got.key_down, want.key_down);
        end
        if ($urandom_range(0, 23) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 4);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (holdoff_req) begin
        holdoff_left = HoldOffLen;
        holdoff_req  = 1'b0;
      end
      m_axis_tready <= (out_stall == 0) && (holdoff_left == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input alkd_reg_e idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegLowThr:  player_cfg.low_thr    = value[11:0];
      RegMidThr:  player_cfg.mid_thr    = value[11:0];
      RegHold:    player_cfg.hold_ticks = value[7:0];
      RegStep:    player_cfg.vol_step   = value[6:0];
      RegFloor:   player_cfg.vol_floor  = value[6:0];
      RegCeil:    player_cfg.vol_ceil   = value[6:0];
      RegSongTot: player_cfg.song_total = value[4:0];
      RegConfirm: player_cfg.confirm    = value[3:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int low_thr, input int mid_thr, input int hold,
                               input int step, input int vfloor, input int vceil,
                               input int songs, input int confirm);
    reg_write(RegLowThr, low_thr);
    reg_write(RegMidThr, mid_thr);
    reg_write(RegHold, hold);
    reg_write(RegStep, step);
    reg_write(RegFloor, vfloor);
    reg_write(RegCeil, vceil);
    reg_write(RegSongTot, songs);
    reg_write(RegConfirm, confirm);
  endtask

  // Wait until every tick is taken and every result checked; a tick just
  // picked up by the sender this edge still counts as pending
  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || in_next_valid ||
           status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_tick(input int sample, input bit boot);
    tick_t t;
    t.sample = 12'(sample);
    t.boot   = boot;
    tick_q.push_back(t);
  endfunction

  // Pick a sample that decodes to the given key under the current thresholds
  function automatic int pick_sample(input alkd_key_e k);
    int lo_t, mid_t, top;
    lo_t  = player_cfg.low_thr;
    mid_t = player_cfg.mid_thr;
    top   = (lo_t > mid_t) ? lo_t : mid_t;
    if (k == KeyMid && mid_t > lo_t)
      return ($urandom_range(0, 5) == 0) ? mid_t - 1 : $urandom_range(lo_t, mid_t - 1);
    if (k != KeyNone && lo_t > 0)
      return ($urandom_range(0, 5) == 0) ? lo_t - 1 : $urandom_range(0, lo_t - 1);
    return ($urandom_range(0, 5) == 0) ? top : $urandom_range(top, 4095);
  endfunction

  // Queue a mix of key presses, boot presses and noise, at least n_ticks ticks in all
  task automatic queue_phase_traffic(input int n_ticks);
    int        pushed, r, len, hold, i;
    alkd_key_e k;
    pushed = 0;
    hold   = player_cfg.hold_ticks;
    while (pushed < n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // Press, hold for len ticks, release
        k = (r < 40) ? KeyLow : KeyMid;
        case ($urandom_range(0, 5))
          0, 1, 2: len = $urandom_range(1, 3);
          3:       len = hold;
          4:       len = hold + 1;
          default: len = hold + 2 + $urandom_range(0, 2);
        endcase
        if (len > 40 && $urandom_range(0, 7) != 0) len = $urandom_range(1, 3);
        if (len < 1) len = 1;
        push_tick(pick_sample(k), 1'b1);
        pushed++;
        for (i = 1; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_tick($urandom_range(0, 4095), 1'b0);
            pushed++;
          end
          push_tick(pick_sample(($urandom_range(0, 3) == 0) ? KeyMid : k), 1'b1);
          pushed++;
        end
        push_tick(pick_sample(KeyNone), 1'b1);
        pushed++;
      end else if (r < 82) begin
        // Boot press of random length, then let go
        len = $urandom_range(1, int'(player_cfg.confirm) + 2);
        for (i = 0; i < len; i++) begin
          push_tick($urandom_range(0, 4095), 1'b0);
          pushed++;
        end
        push_tick(pick_sample(KeyNone), 1'b1);
        pushed++;
      end else begin
        // Raw noise
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          push_tick($urandom_range(0, 4095), $urandom_range(0, 3) != 0);
          pushed++;
        end
      end
    end
  endtask

  // Stimulus: reset, directed ticks, then random phases under several settings
  initial begin
    int phase;
    reset_player();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: tap, key change while latched, boot freeze, confirm, wrap, ceiling
    push_tick(4095, 1'b1);
    push_tick(0, 1'b1);
    push_tick(399, 1'b1);
    push_tick(400, 1'b1);
    push_tick(4095, 1'b1);
    push_tick(2799, 1'b1);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(2800, 1'b1);
    push_tick(0, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(0, 1'b0);
    push_tick(0, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(100, 1'b1);
    push_tick(4095, 1'b1);
    push_tick(100, 1'b1);
    push_tick(4095, 1'b1);
    push_tick(100, 1'b1);
    push_tick(4095, 1'b1);
    wait_drained();

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: load_settings(400, 2800, 4, 10, 10, 100, 3, 2);
        1: load_settings(0, 4095, 1, 1, 0, 100, 16, 1);
        2: load_settings(4095, 0, 254, 100, 100, 100, 1, 15);
        3: load_settings(1000, 3000, 6, 7, 20, 80, 5, 3);
        4: load_settings(2000, 1000, 3, 100, 0, 0, 2, 1);
        default: load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(1, 10), $urandom_range(1, 100),
                               $urandom_range(0, 100), $urandom_range(0, 100),
                               $urandom_range(1, 16), $urandom_range(1, 15));
      endcase
      queue_phase_traffic(60);
      if (phase == 0 || $urandom_range(0, 2) == 0) holdoff_req = 1'b1;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("results left over", 0, status_q.size());
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/alkd_pkg.sv
hdl/alkd_cfg_regs.sv
hdl/alkd_core.sv
hdl/adc_ladder_key_decoder_unit.sv
tb/adc_ladder_key_decoder_unit_tb.sv
